[rtl/assert_macros.svh]
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define BPME_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define BPME_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/bpme_pkg.sv]
// Shared types, codes and arithmetic helpers of the polynomial map evaluator.
package bpme_pkg;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WALK,
        ST_DRAIN,
        ST_FIN
    } t_state;

    // register indexes of the config port
    localparam logic CFG_TERMS = 1'b0;
    localparam logic CFG_MODE  = 1'b1;

    // dimension modes
    localparam logic [1:0] MODE_1D = 2'd1;
    localparam logic [1:0] MODE_2D = 2'd2;

    // input word actions
    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_MAP  = 1'b1;

    localparam logic [3:0] TERMS_RST = 4'd1;
    localparam logic [1:0] MODE_RST  = 2'd2;

    localparam int FRAC_SH   = 14;  // Q2.14 fraction bits
    localparam int PROD_W    = 48;  // coefficient x monomial product
    localparam int PROD_SH_W = 34;  // product after the Q2.14 shift

    localparam logic signed [15:0] MONO_ONE = 16'sd16384;
    localparam logic signed [17:0] MONO_MAX = 18'sd32767;
    localparam logic signed [17:0] MONO_MIN = -18'sd32768;

    // Q2.14 x Q2.14, floor shift, clip to 16 bits
    function automatic logic signed [15:0] mono_mul(logic signed [15:0] m,
                                                    logic signed [15:0] f);
        logic signed [31:0] p;
        logic signed [17:0] s;
        logic signed [15:0] r;
        p = 32'(m) * 32'(f);
        s = 18'(p >>> FRAC_SH);
        if (s > MONO_MAX) begin
            r = 16'sd32767;
        end else if (s < MONO_MIN) begin
            r = -16'sd32768;
        end else begin
            r = 16'(s);
        end
        return r;
    endfunction

endpackage

[rtl/bpme_in_if.sv]
// Input channel: coefficient load and map request words.
interface bpme_in_if;
    logic               valid;
    logic               ready;
    logic               action;
    logic [2:0]         group;
    logic [2:0]         column;
    logic               out_row;
    logic signed [31:0] coeff_value;
    logic signed [15:0] point_x;
    logic signed [15:0] point_y;

    modport source (
        output valid, action, group, column, out_row, coeff_value, point_x, point_y,
        input  ready
    );
    modport sink (
        input  valid, action, group, column, out_row, coeff_value, point_x, point_y,
        output ready
    );
endinterface

[rtl/bpme_out_if.sv]
// Output channel: mapped point words.
interface bpme_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] mapped_x;
    logic signed [31:0] mapped_y;
    logic               mode_error;
    logic               saturated;

    modport source (
        output valid, mapped_x, mapped_y, mode_error, saturated,
        input  ready
    );
    modport sink (
        input  valid, mapped_x, mapped_y, mode_error, saturated,
        output ready
    );
    modport monitor (
        input valid, ready, mapped_x, mapped_y, mode_error, saturated
    );
endinterface

[rtl/bpme_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module bpme_ram #(
    parameter int W     = 32,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [W-1:0]  i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [W-1:0]  o_rdata
);
    logic [W-1:0] r_mem [DEPTH];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

[rtl/bivariate_polynomial_map_eval_core.sv]
// Polynomial map evaluator: maps a Q2.14 point through a stored bivariate polynomial.
// Load word: written straight into the coefficient RAMs when taken, no result.
// Map word: walks the n(n+1)/2 terms (n = groups in use), one RAM read and monomial step
// per term, drains the term pipeline and registers the result; no new word is taken until
// then. Reset: synchronous, active low; terms_in_use = 1, dimension_mode = 2, then a
// clearing pass zeroes all MAX_GROUPS*MAX_GROUPS RAM addresses with input ready low.
module bivariate_polynomial_map_eval_core #(
    parameter int MAX_GROUPS = 8
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    bpme_in_if.sink      i_in,
    bpme_out_if.source   o_out,
    input  logic         i_cfg_we,
    input  logic         i_cfg_idx,
    input  logic [3:0]   i_cfg_data
);
    import bpme_pkg::*;

    // ------------------------------------------------------------------
    // Sizes
    // ------------------------------------------------------------------
    localparam int GW     = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;  // group / column
    localparam int NW     = $clog2(MAX_GROUPS + 1);                     // groups in use
    localparam int CW     = NW + 1;                                     // compare width
    localparam int DEPTH  = MAX_GROUPS * MAX_GROUPS;
    localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int TERMS  = MAX_GROUPS * (MAX_GROUPS + 1) / 2;
    localparam int ACC_W  = PROD_SH_W + $clog2(TERMS + 1);

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    t_state r_state, n_state;

    logic [AW-1:0]          r_clr;        // clearing pass address
    logic [3:0]             r_terms;      // config: groups in use
    logic [1:0]             r_mode;       // config: dimension mode

    // per-point context, latched at accept
    logic signed [15:0]     r_x, r_y;
    logic [NW-1:0]          r_n;
    logic                   r_one_d;
    logic                   r_err;

    // walk: a = power of x, j = power of y, d = a + j
    logic [GW-1:0]          r_a, r_j;
    logic signed [15:0]     r_m;          // x^a * y^j for the current (a, j)
    logic signed [15:0]     r_xb;         // x^a, base of the current row

    // term pipeline: RAM read -> products -> accumulate
    logic                   r_v1, r_v2;
    logic signed [15:0]     r_m1;
    logic signed [PROD_W-1:0] r_p0, r_p1;
    logic signed [ACC_W-1:0]  r_acc0, r_acc1;

    // output register
    logic                   r_ovalid;
    logic signed [31:0]     r_omx, r_omy;
    logic                   r_oerr, r_osat;

    // ------------------------------------------------------------------
    // Handshakes
    // ------------------------------------------------------------------
    logic w_in_acc, w_out_acc, w_out_free;
    assign i_in.ready = (r_state == ST_IDLE);
    assign w_in_acc   = i_in.valid && i_in.ready;
    assign w_out_acc  = r_ovalid && o_out.ready;
    assign w_out_free = !r_ovalid || o_out.ready;

    // ------------------------------------------------------------------
    // Coefficient RAMs, one per output row. Address = group*MAX_GROUPS + column.
    // ------------------------------------------------------------------
    logic [31:0]   w_wlin, w_rlin;
    logic [AW-1:0] w_waddr, w_raddr;
    logic          w_load_ok;
    logic          w_we0, w_we1;
    logic [31:0]   w_wdata;
    logic [31:0]   w_rd0, w_rd1;

    assign w_load_ok = w_in_acc && (i_in.action == ACT_LOAD)
                       && (32'(i_in.group) < 32'(MAX_GROUPS))
                       && (i_in.column <= i_in.group);
    assign w_wlin  = 32'(i_in.group) * 32'(MAX_GROUPS) + 32'(i_in.column);
    assign w_waddr = (r_state == ST_CLEAR) ? r_clr : w_wlin[AW-1:0];
    assign w_wdata = (r_state == ST_CLEAR) ? 32'd0 : i_in.coeff_value;
    assign w_we0   = (r_state == ST_CLEAR) || (w_load_ok && !i_in.out_row);
    assign w_we1   = (r_state == ST_CLEAR) || (w_load_ok && i_in.out_row);

    bpme_ram #(.W(32), .DEPTH(DEPTH), .AW(AW)) u_ram0 (
        .i_clk   (i_clk),
        .i_we    (w_we0),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rd0)
    );

    bpme_ram #(.W(32), .DEPTH(DEPTH), .AW(AW)) u_ram1 (
        .i_clk   (i_clk),
        .i_we    (w_we1),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rd1)
    );

    // ------------------------------------------------------------------
    // Walk order: for each a, j runs up while a + j < n. The monomial for
    // (a, j+1) is the one for (a, j) times y, and the row base for a+1 is
    // x^a times x, which keeps the model's x-first, then-y clipping order.
    // ------------------------------------------------------------------
    logic [CW-1:0]      w_d;
    logic               w_row_end, w_all_end;
    logic signed [15:0] w_mono;

    assign w_d       = CW'(r_a) + CW'(r_j);
    assign w_row_end = (w_d + CW'(1)) >= CW'(r_n);
    assign w_all_end = w_row_end && ((CW'(r_a) + CW'(1)) >= CW'(r_n));
    assign w_rlin    = 32'(w_d) * 32'(MAX_GROUPS) + 32'(r_j);
    assign w_raddr   = w_rlin[AW-1:0];
    assign w_mono    = w_row_end ? mono_mul(r_xb, r_x) : mono_mul(r_m, r_y);

    // ------------------------------------------------------------------
    // Output saturation: clip when the bits above bit 31 disagree with it.
    // ------------------------------------------------------------------
    logic               w_hit0, w_hit1;
    logic signed [31:0] w_sat0, w_sat1;

    assign w_hit0 = !((&r_acc0[ACC_W-1:31]) || !(|r_acc0[ACC_W-1:31]));
    assign w_hit1 = !((&r_acc1[ACC_W-1:31]) || !(|r_acc1[ACC_W-1:31]));
    assign w_sat0 = !w_hit0 ? 32'(r_acc0) :
                    (r_acc0[ACC_W-1] ? 32'sh8000_0000 : 32'sh7FFF_FFFF);
    assign w_sat1 = !w_hit1 ? 32'(r_acc1) :
                    (r_acc1[ACC_W-1] ? 32'sh8000_0000 : 32'sh7FFF_FFFF);

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    logic w_start_ok;  // supported mode and at least one group
    assign w_start_ok = ((r_mode == MODE_1D) || (r_mode == MODE_2D)) && (r_terms != 4'd0);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: begin
                if (r_clr == AW'(DEPTH - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (w_in_acc && (i_in.action == ACT_MAP)) begin
                    n_state = w_start_ok ? ST_WALK : ST_FIN;
                end
            end
            ST_WALK: begin
                if (w_all_end) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!r_v1 && !r_v2) begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_CLEAR;
            r_clr    <= '0;
            r_terms  <= TERMS_RST;
            r_mode   <= MODE_RST;
            r_v1     <= 1'b0;
            r_v2     <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_CLEAR) begin
                r_clr <= r_clr + AW'(1);
            end
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_TERMS: r_terms <= i_cfg_data;
                    CFG_MODE:  r_mode  <= i_cfg_data[1:0];
                    default:   r_mode  <= r_mode;
                endcase
            end
            r_v1 <= (r_state == ST_WALK);
            r_v2 <= r_v1;
            if ((r_state == ST_FIN) && w_out_free) begin
                r_ovalid <= 1'b1;
            end else if (w_out_acc) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if ((r_state == ST_IDLE) && w_in_acc && (i_in.action == ACT_MAP)) begin
            r_x     <= i_in.point_x;
            r_y     <= (r_mode == MODE_1D) ? 16'sd0 : i_in.point_y;
            r_one_d <= (r_mode == MODE_1D);
            r_err   <= !((r_mode == MODE_1D) || (r_mode == MODE_2D));
            r_n     <= (32'(r_terms) > 32'(MAX_GROUPS)) ? NW'(MAX_GROUPS) : NW'(r_terms);
            r_a     <= '0;
            r_j     <= '0;
            r_m     <= MONO_ONE;
            r_xb    <= MONO_ONE;
            r_acc0  <= '0;
            r_acc1  <= '0;
        end else begin
            if (r_state == ST_WALK) begin
                r_m <= w_mono;
                if (w_row_end) begin
                    r_a  <= r_a + GW'(1);
                    r_j  <= '0;
                    r_xb <= w_mono;
                end else begin
                    r_j <= r_j + GW'(1);
                end
            end
            if (r_v2) begin
                r_acc0 <= r_acc0 + ACC_W'(r_p0 >>> FRAC_SH);
                r_acc1 <= r_acc1 + ACC_W'(r_p1 >>> FRAC_SH);
            end
        end
        // monomial is registered in step with its RAM read data
        r_m1 <= r_m;
        r_p0 <= PROD_W'($signed(w_rd0)) * PROD_W'(r_m1);
        r_p1 <= PROD_W'($signed(w_rd1)) * PROD_W'(r_m1);
        if ((r_state == ST_FIN) && w_out_free) begin
            r_oerr <= r_err;
            r_omx  <= r_err ? 32'sd0 : w_sat0;
            r_omy  <= (r_err || r_one_d) ? 32'sd0 : w_sat1;
            r_osat <= !r_err && (w_hit0 || (!r_one_d && w_hit1));
        end
    end

    assign o_out.valid      = r_ovalid;
    assign o_out.mapped_x   = r_omx;
    assign o_out.mapped_y   = r_omy;
    assign o_out.mode_error = r_oerr;
    assign o_out.saturated  = r_osat;
endmodule

[rtl/bpme_checker.sv]
// Port-level checks on the result channel, bound to the top level.
`include "assert_macros.svh"

module bpme_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        i_ready,
    input logic [31:0] i_mapped_x,
    input logic [31:0] i_mapped_y,
    input logic        i_mode_error,
    input logic        i_saturated
);
    `BPME_ASSERT_IMP(a_err_zero, i_clk, i_rst_n, i_valid && i_mode_error, i_mapped_x == 32'h0 && i_mapped_y == 32'h0 && !i_saturated, "mode error word carries data")

    `BPME_ASSERT_IMP(a_sat_limit, i_clk, i_rst_n, i_valid && i_saturated, i_mapped_x == 32'h7FFF_FFFF || i_mapped_x == 32'h8000_0000 || i_mapped_y == 32'h7FFF_FFFF || i_mapped_y == 32'h8000_0000, "saturated word not at a limit")

    `BPME_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, i_valid && !i_ready, i_valid && $stable(i_mapped_x) && $stable(i_mapped_y) && $stable(i_saturated) && $stable(i_mode_error), "stalled result word changed")
endmodule

bind bivariate_polynomial_map_eval_core bpme_checker u_bpme_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_valid      (o_out.valid),
    .i_ready      (o_out.ready),
    .i_mapped_x   (o_out.mapped_x),
    .i_mapped_y   (o_out.mapped_y),
    .i_mode_error (o_out.mode_error),
    .i_saturated  (o_out.saturated)
);
